[hw/rtl/schp_pkg.sv]
// shared types, codes and constants of the size class handle pool
`default_nettype none

package schp_pkg;

    // fixed field widths
    localparam int REQ_W      = 2;
    localparam int SIZE_W     = 32;
    localparam int CLS_ID_W   = 2;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int FIT_W      = 2;
    localparam int BYTES_W    = 26;
    localparam int EMPTY_W    = 4;
    localparam int LIMIT_W    = 16;
    localparam int KB_SHIFT   = 10;
    localparam int NREG       = 4;
    localparam int CFG_ADDR_W = 2;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 8;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 8;

    // parameter defaults
    localparam int NUM_CLASSES_DEF = 4;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET [NREG] = '{
        16'd64, 16'd256, 16'd1024, 16'd4096
    };

    typedef enum logic [REQ_W-1:0] {
        REQ_FIT     = 2'd0,
        REQ_SPAWN   = 2'd1,
        REQ_DESPAWN = 2'd2,
        REQ_QUERY   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOFIT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[hw/rtl/schp_ctrl.sv]
// request sequencer of the size class handle pool
`default_nettype none

module schp_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire schp_pkg::stat_t stat,
    output schp_pkg::cmd_t      cmd
);

    schp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= schp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            schp_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = schp_pkg::S_EXEC;
                end
            end
            schp_pkg::S_EXEC: begin
                state_next = schp_pkg::S_DONE;
            end
            schp_pkg::S_DONE: begin
                if (stat.out_free) begin
                    state_next = schp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = schp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            schp_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            schp_pkg::S_EXEC: begin
                cmd.exec = 1'b1;
            end
            schp_pkg::S_DONE: begin
                cmd.load = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/schp_dp.sv]
// datapath of the size class handle pool: limits, stack counts, handle memory, result register
`default_nettype none

module schp_dp #(
    parameter int NUM_CLASSES = schp_pkg::NUM_CLASSES_DEF,
    parameter int STACK_DEPTH = schp_pkg::STACK_DEPTH_DEF,
    parameter int HANDLE_BITS = schp_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire schp_pkg::cmd_t                   cmd,
    output schp_pkg::stat_t                       stat,
    input  wire logic                             cfg_we,
    input  wire logic [schp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [schp_pkg::LIMIT_W-1:0]     cfg_wdata,
    input  wire logic [schp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [schp_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [schp_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [schp_pkg::M_TUSER_W-1:0]        m_tuser
);

    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MEM_D  = NUM_CLASSES * STACK_DEPTH;
    localparam int ADDR_W = (MEM_D > 1) ? $clog2(MEM_D) : 1;

    // configuration
    logic [schp_pkg::LIMIT_W-1:0] limit_reg [schp_pkg::NREG];

    // latched request
    logic [schp_pkg::REQ_W-1:0]    req_type_reg;
    logic [schp_pkg::SIZE_W-1:0]   req_size_reg;
    logic [schp_pkg::CLS_ID_W-1:0] req_cls_reg;
    logic [schp_pkg::HANDLE_W-1:0] req_handle_reg;

    // stack state
    logic [CNT_W-1:0]       count_reg [NUM_CLASSES];
    logic [HANDLE_BITS-1:0] mem [MEM_D];
    logic [HANDLE_BITS-1:0] rdata_reg;

    // pending result
    schp_pkg::status_t          pend_status_reg, pend_status_next;
    logic [schp_pkg::FIT_W-1:0] pend_fit_reg, pend_fit_next;
    logic                       pend_pop_reg;

    // output register
    logic                          m_tvalid_reg, m_tvalid_next;
    schp_pkg::status_t             out_status_reg;
    logic [schp_pkg::FIT_W-1:0]    out_fit_reg;
    logic [schp_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [schp_pkg::BYTES_W-1:0]  out_bytes_reg;
    logic [schp_pkg::EMPTY_W-1:0]  out_empty_reg;

    logic                          cls_valid;
    logic [CLS_W-1:0]              cls_idx;
    logic [CNT_W-1:0]              cur_count;
    logic                          stack_empty, stack_full;
    logic                          do_pop, do_push;
    logic [PTR_W-1:0]              ptr;
    logic [ADDR_W-1:0]             addr;
    logic [schp_pkg::NREG-1:0]     hit;
    logic [schp_pkg::BYTES_W-1:0]  bytes_now;
    logic [schp_pkg::EMPTY_W-1:0]  empty_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < schp_pkg::NREG; i++) begin
                limit_reg[i] <= schp_pkg::LIMIT_RESET[i];
            end
        end else if (cfg_we) begin
            limit_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // s_tdata: required_size [31:0], class_id [33:32], handle [49:34]
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_type_reg   <= s_tuser[schp_pkg::REQ_W-1:0];
            req_size_reg   <= s_tdata[31:0];
            req_cls_reg    <= s_tdata[33:32];
            req_handle_reg <= s_tdata[49:34];
        end
    end

    assign cls_valid   = 32'(req_cls_reg) < NUM_CLASSES;
    assign cls_idx     = CLS_W'(req_cls_reg);
    assign cur_count   = count_reg[cls_idx];
    assign stack_empty = !cls_valid || (cur_count == '0);
    assign stack_full  = !cls_valid || (cur_count >= CNT_W'(STACK_DEPTH));

    // fit compare against every existing class
    always_comb begin
        for (int c = 0; c < schp_pkg::NREG; c++) begin
            hit[c] = (c < NUM_CLASSES) &&
                     (req_size_reg <= 32'({limit_reg[c], 10'b0}));
        end
    end

    always_comb begin
        pend_status_next = schp_pkg::ST_OK;
        pend_fit_next    = '0;
        do_pop           = 1'b0;
        do_push          = 1'b0;
        case (req_type_reg)
            schp_pkg::REQ_FIT: begin
                pend_status_next = schp_pkg::ST_NOFIT;
                for (int c = schp_pkg::NREG - 1; c >= 0; c--) begin
                    if (hit[c]) begin
                        pend_status_next = schp_pkg::ST_OK;
                        pend_fit_next    = schp_pkg::FIT_W'(c);
                    end
                end
            end
            schp_pkg::REQ_SPAWN: begin
                if (stack_empty) begin
                    pend_status_next = schp_pkg::ST_EMPTY;
                end else begin
                    do_pop = 1'b1;
                end
            end
            schp_pkg::REQ_DESPAWN: begin
                if (stack_full) begin
                    pend_status_next = schp_pkg::ST_FULL;
                end else begin
                    do_push = 1'b1;
                end
            end
            default: begin
                pend_status_next = schp_pkg::ST_OK;
            end
        endcase
    end

    assign ptr  = do_pop ? PTR_W'(cur_count - 1'b1) : PTR_W'(cur_count);
    assign addr = ADDR_W'(cls_idx) * ADDR_W'(STACK_DEPTH) + ADDR_W'(ptr);

    always_ff @(posedge aclk) begin
        if (cmd.exec && do_push) begin
            mem[addr] <= HANDLE_BITS'(req_handle_reg);
        end
        if (cmd.exec && do_pop) begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                count_reg[i] <= '0;
            end
        end else if (cmd.exec) begin
            if (do_push) begin
                count_reg[cls_idx] <= cur_count + 1'b1;
            end else if (do_pop) begin
                count_reg[cls_idx] <= cur_count - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            pend_status_reg <= pend_status_next;
            pend_fit_reg    <= pend_fit_next;
            pend_pop_reg    <= do_pop;
        end
    end

    assign bytes_now = cls_valid ? {limit_reg[req_cls_reg], 10'b0} : '0;

    for (genvar c = 0; c < schp_pkg::EMPTY_W; c++) begin : g_empty
        if (c < NUM_CLASSES) begin : g_real
            assign empty_now[c] = (count_reg[c] == '0);
        end else begin : g_none
            assign empty_now[c] = 1'b1;
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_status_reg <= pend_status_reg;
            out_fit_reg    <= pend_fit_reg;
            out_handle_reg <= pend_pop_reg ? schp_pkg::HANDLE_W'(rdata_reg) : '0;
            out_bytes_reg  <= bytes_now;
            out_empty_reg  <= empty_now;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_empty_reg, out_bytes_reg, out_handle_reg, out_fit_reg};
    assign m_tuser  = {6'b0, out_status_reg};

endmodule

`default_nettype wire

[hw/rtl/size_class_handle_pool_core.sv]
// top level of the size class handle pool
//
//  channel   direction  signals                      word
//  s_        in         s_tvalid s_tready s_tdata    one request
//                       s_tuser
//  m_        out        m_tvalid m_tready m_tdata    one result
//                       m_tuser
//  cfg_      in         cfg_we cfg_addr cfg_wdata    one class limit in kb
//
//  each request steps through capture, execute (one pass through the
//  count file and the single handle memory port) and result load
//  a pop reads the handle memory with a registered read that lands by the load cycle
//  the result register lets the next word be taken while a result waits;
//  a later result waits in the load cycle until the result register frees up
//  reset clears the fill counts and the output valid at once; no clearing
//  pass, the handle memory holds garbage until pushed
`default_nettype none

module size_class_handle_pool_core #(
    parameter int NUM_CLASSES = schp_pkg::NUM_CLASSES_DEF,
    parameter int STACK_DEPTH = schp_pkg::STACK_DEPTH_DEF,
    parameter int HANDLE_BITS = schp_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write port, index 0..3 selects class_limit_kb_0..3
    input  wire logic                             cfg_we,
    input  wire logic [schp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [schp_pkg::LIMIT_W-1:0]     cfg_wdata,
    // request channel
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // required_size [31:0], class_id [33:32], handle [49:34], zero [55:50]
    input  wire logic [schp_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type [1:0], zero [7:2]
    input  wire logic [schp_pkg::S_TUSER_W-1:0]   s_tuser,
    // result channel
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // fit_class [1:0], handle_out [17:2], class_bytes [43:18], empty_mask [47:44]
    output logic [schp_pkg::M_TDATA_W-1:0]        m_tdata,
    // status [1:0], zero [7:2]
    output logic [schp_pkg::M_TUSER_W-1:0]        m_tuser
);

    // command and status between sequencer and datapath
    schp_pkg::cmd_t  cmd;
    schp_pkg::stat_t stat;

    // sequencer: one request in flight, steps capture, execute, load
    schp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: limit registers, fit compare, stack counts, handle memory,
    // result register
    schp_dp #(
        .NUM_CLASSES (NUM_CLASSES),
        .STACK_DEPTH (STACK_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[hw/rtl/schp_checker.sv]
// port checks of the size class handle pool and their binding
`default_nettype none

module schp_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [schp_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [schp_pkg::M_TUSER_W-1:0]  m_tuser
);

    // a taken request closes the input until its work is done
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in flight");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // only a successful request carries a handle or a fit class
    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] != schp_pkg::ST_OK)) |->
            ((m_tdata[17:2] == '0) && (m_tdata[1:0] == '0)))
        else $error("failed request carries handle or fit class");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind size_class_handle_pool_core schp_checker u_schp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/size_class_pool_checker.sv]
// checker that predicts and compares every result word of the size class handle pool
module size_class_pool_checker
    import schp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [LIMIT_W-1:0]     cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [M_TUSER_W-1:0]   m_tuser,
    output int                     mismatch_count,
    output int                     words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLASSES = NUM_CLASSES_DEF;
    localparam int DEPTH   = STACK_DEPTH_DEF;

    // request word layout
    localparam int CLS_LO    = SIZE_W;
    localparam int HANDLE_LO = CLS_LO + CLS_ID_W;
    // result word layout
    localparam int HOUT_LO   = FIT_W;
    localparam int BYTES_LO  = HOUT_LO + HANDLE_W;
    localparam int EMPTY_LO  = BYTES_LO + BYTES_W;

    typedef struct packed {
        status_t               status;
        logic [FIT_W-1:0]      fit_class;
        logic [HANDLE_W-1:0]   handle_out;
        logic [BYTES_W-1:0]    class_bytes;
        logic [EMPTY_W-1:0]    empty_mask;
    } pool_result_t;

    logic [LIMIT_W-1:0]  limit_kb [NREG];
    logic [HANDLE_W-1:0] free_stack [CLASSES][DEPTH];
    int unsigned         fill [CLASSES];
    pool_result_t        expected_results [$];
    int                  errors = 0;

    function automatic logic [BYTES_W-1:0] class_size_bytes(input int unsigned cls);
        if (cls >= CLASSES || cls >= NREG)
            return '0;
        return BYTES_W'(limit_kb[cls]) << KB_SHIFT;
    endfunction

    // updates the pool copy and returns the result word the request must produce
    function automatic pool_result_t apply_request(input req_t req,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [CLS_ID_W-1:0] cls,
                                                   input logic [HANDLE_W-1:0] h);
        pool_result_t r;
        logic         known;
        int           c;
        r        = '0;
        r.status = ST_OK;
        known    = cls < CLASSES;
        case (req)
            REQ_FIT: begin
                r.status = ST_NOFIT;
                for (c = 0; c < CLASSES && c < NREG; c++) begin
                    if (r.status == ST_NOFIT && size <= SIZE_W'(class_size_bytes(c))) begin
                        r.status    = ST_OK;
                        r.fit_class = FIT_W'(c);
                    end
                end
            end
            REQ_SPAWN: begin
                if (!known || fill[cls] == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    fill[cls]--;
                    r.handle_out = free_stack[cls][fill[cls]];
                end
            end
            REQ_DESPAWN: begin
                if (!known || fill[cls] >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    free_stack[cls][fill[cls]] = h;
                    fill[cls]++;
                end
            end
            default: ;
        endcase
        r.class_bytes = class_size_bytes(cls);
        for (c = 0; c < EMPTY_W; c++)
            r.empty_mask[c] = (c >= CLASSES) ? 1'b1 : (fill[c] == 0);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        pool_result_t want;
        pool_result_t next_want;
        if (!aresetn) begin
            limit_kb = LIMIT_RESET;
            foreach (fill[c])
                fill[c] = 0;
            expected_results.delete();
        end else begin
            // results leave only after their request has passed execute and load, so compare first
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no request outstanding");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_tuser[STATUS_W-1:0]);
                    check_field("fit_class", want.fit_class, m_tdata[0 +: FIT_W]);
                    check_field("handle_out", want.handle_out, m_tdata[HOUT_LO +: HANDLE_W]);
                    check_field("class_bytes", want.class_bytes, m_tdata[BYTES_LO +: BYTES_W]);
                    check_field("empty_mask", want.empty_mask, m_tdata[EMPTY_LO +: EMPTY_W]);
                end
            end
            if (s_tvalid && s_tready) begin
                next_want = apply_request(req_t'(s_tuser[REQ_W-1:0]),
                                          s_tdata[0 +: SIZE_W],
                                          s_tdata[CLS_LO +: CLS_ID_W],
                                          s_tdata[HANDLE_LO +: HANDLE_W]);
                expected_results.insert(expected_results.size(), next_want);
            end
            if (cfg_we && cfg_addr < NREG)
                limit_kb[cfg_addr] = cfg_wdata;
        end
        mismatch_count <= errors;
        words_pending  <= expected_results.size();
    end

endmodule

[tb/tb_size_class_handle_pool_core.sv]
// testbench top: stimulus, idling, limit settings and verdict for the size class handle pool
module tb_size_class_handle_pool_core;
    timeunit 1ns;
    timeprecision 1ps;

    import schp_pkg::*;

    localparam int NUM_ROUNDS       = 6;    // one limit setting per round
    localparam int RANDOM_PER_ROUND = 80;
    localparam int CHUNK_LEN        = 16;   // words sharing one hot class and push bias
    localparam int HOLD_OFF_CYCLES  = 80;   // long receiver stall, fills the block
    localparam int SETTLE_CYCLES    = 8;
    localparam int STALL_LIMIT      = 2000; // cycles without any handshake

    typedef logic [LIMIT_W-1:0] limit_set_t [NREG];

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [LIMIT_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // required_size [31:0], class_id [33:32], handle [49:34], zero [55:50]
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // req_type [1:0], zero [7:2]
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // fit_class [1:0], handle_out [17:2], class_bytes [43:18], empty_mask [47:44]
    logic [M_TDATA_W-1:0]  m_tdata;
    // status [1:0], zero [7:2]
    logic [M_TUSER_W-1:0]  m_tuser;

    int          mismatch_count;
    int          words_pending;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_off_req  = 1'b0;
    logic        hold_off_done = 1'b0;
    int          quiet_cycles  = 0;
    // limits as last written, used to aim fit sizes at the class boundaries
    limit_set_t  limits;

    always #5 aclk = ~aclk;

    size_class_handle_pool_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    size_class_pool_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // offers one request word and returns at the edge that accepts it;
    // called right after a rising edge
    task automatic send_request(input req_t req, input logic [SIZE_W-1:0] size,
                                input logic [CLS_ID_W-1:0] cls,
                                input logic [HANDLE_W-1:0] h);
        // sender gaps, one cycle at a time so they land on any phase of the block
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({h, cls, size});
        s_tuser  <= S_TUSER_W'(req);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // random request; push_pct biases despawn over spawn so that stacks
    // swing between empty and full, mostly on the hot class
    task automatic send_random_request(input logic [CLS_ID_W-1:0] hot_cls,
                                       input int unsigned push_pct);
        int unsigned         pick;
        req_t                req;
        logic [CLS_ID_W-1:0] cls;
        logic [SIZE_W-1:0]   size;
        pick = $urandom_range(99);
        cls  = ($urandom_range(99) < 70) ? hot_cls : CLS_ID_W'($urandom_range(3));
        if (pick < 15)
            req = REQ_FIT;
        else if (pick < 20)
            req = REQ_QUERY;
        else if ($urandom_range(99) < push_pct)
            req = REQ_DESPAWN;
        else
            req = REQ_SPAWN;
        case ($urandom_range(3))
            0:       size = $urandom;
            1:       size = SIZE_W'($urandom_range(4095));
            // one below, at or one above a class boundary
            default: size = (SIZE_W'(limits[$urandom_range(NREG - 1)]) << KB_SHIFT)
                            + SIZE_W'($urandom_range(2)) - SIZE_W'(1);
        endcase
        send_request(req, size, cls, HANDLE_W'($urandom));
    endtask

    // drop valid and wait until every result word is back, then let the block settle
    task automatic drain_pool();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one register per cycle, only while the block is idle
    task automatic write_limits(input limit_set_t vals);
        for (int i = 0; i < NREG; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(i);
            cfg_wdata <= vals[i];
            limits[i] = vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver: random ready, plus one long hold-off while the sender keeps offering
    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: any accepted word on either channel restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_size_class_handle_pool_core: errors");
            $finish;
        end
    end

    initial begin : stimulus
        limit_set_t          next_limits;
        logic [CLS_ID_W-1:0] hot_cls;
        int unsigned         push_pct;
        limits = LIMIT_RESET;
        hot_cls  = '0;
        push_pct = 50;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fit at size zero, on and past the first and the last boundary, the largest size
        send_request(REQ_FIT, 32'd0, 2'd0, 16'd0);
        send_request(REQ_FIT, 32'd65536, 2'd0, 16'd0);
        send_request(REQ_FIT, 32'd65537, 2'd1, 16'd0);
        send_request(REQ_FIT, 32'd4194304, 2'd2, 16'd0);
        send_request(REQ_FIT, 32'd4194305, 2'd3, 16'd0);
        send_request(REQ_FIT, 32'hFFFF_FFFF, 2'd0, 16'hFFFF);
        // size query of every class leaves the pool alone
        send_request(REQ_QUERY, 32'hFFFF_FFFF, 2'd0, 16'hFFFF);
        send_request(REQ_QUERY, 32'd0, 2'd1, 16'd0);
        send_request(REQ_QUERY, 32'd0, 2'd2, 16'd0);
        send_request(REQ_QUERY, 32'd0, 2'd3, 16'd0);
        // spawn from an empty class, then pushes with extreme handles
        send_request(REQ_SPAWN, 32'd0, 2'd2, 16'd0);
        send_request(REQ_DESPAWN, 32'd0, 2'd0, 16'hFFFF);
        send_request(REQ_DESPAWN, 32'd0, 2'd0, 16'd0);
        send_request(REQ_DESPAWN, 32'd0, 2'd3, 16'hA5A5);
        send_request(REQ_DESPAWN, 32'd0, 2'd1, 16'h5A5A);
        // pops come back in last-in first-out order, the third one finds it empty
        send_request(REQ_SPAWN, 32'd0, 2'd0, 16'd0);
        send_request(REQ_SPAWN, 32'd0, 2'd0, 16'd0);
        send_request(REQ_SPAWN, 32'd0, 2'd0, 16'd0);
        send_request(REQ_SPAWN, 32'd0, 2'd3, 16'd0);
        send_request(REQ_SPAWN, 32'd0, 2'd1, 16'd0);
        drain_pool();

        for (int round = 0; round < NUM_ROUNDS; round++) begin
            // limit settings: reset values, all max, all zero, out of order, random
            case (round)
                0: next_limits = LIMIT_RESET;
                1: next_limits = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: next_limits = '{16'd0, 16'd0, 16'd0, 16'd0};
                3: next_limits = '{16'd1, 16'hFFFF, 16'd0, 16'd300};
                4: foreach (next_limits[i]) next_limits[i] = LIMIT_W'($urandom);
                default: foreach (next_limits[i]) next_limits[i] = LIMIT_W'($urandom_range(63));
            endcase
            if (round != 0)
                write_limits(next_limits);

            // idling: sender light and receiver heavy, then swapped, then none
            case (round % 3)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (round == 2)
                hold_off_req = 1'b1;

            for (int n = 0; n < RANDOM_PER_ROUND; n++) begin
                if (n % CHUNK_LEN == 0) begin
                    hot_cls = CLS_ID_W'($urandom_range(3));
                    case ($urandom_range(2))
                        0:       push_pct = 15;
                        1:       push_pct = 50;
                        default: push_pct = 85;
                    endcase
                end
                send_random_request(hot_cls, push_pct);
            end
            drain_pool();
        end

        if (mismatch_count == 0) begin
            $display("tb_size_class_handle_pool_core: clean");
        end else begin
            $display("tb_size_class_handle_pool_core: errors");
        end
        $finish;
    end

endmodule
